@@ src/dfa_match_length_defines.svh @@
// Assertion helpers for the matcher; clk and arst_n come from the using module.
`ifndef DFA_MATCH_LENGTH_DEFINES_SVH
`define DFA_MATCH_LENGTH_DEFINES_SVH

`ifndef SYNTHESIS
`define DML_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("dfa_match_length: assertion failed");
`define DML_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("dfa_match_length: assertion failed");
`else
`define DML_ASSERT(lbl, prop)
`define DML_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ src/dml_pkg.sv @@
`default_nettype none
package dml_pkg;

	localparam int NUM_STATES  = 256;
	localparam int MAX_LENGTH  = 65535;
	localparam int ST_W        = 8;
	localparam int SYM_W       = 8;
	localparam int LEN_W       = $clog2(MAX_LENGTH + 1);
	localparam int OUT_LEN_W   = 16;
	localparam int OUT_LEN_MAX = 65535;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);
	localparam int S_DATA_W    = 32;
	localparam int M_DATA_W    = 24;

	localparam logic [1:0] STAT_ACCEPT = 2'b01;
	localparam logic [1:0] STAT_REJECT = 2'b10;

	typedef enum logic [1:0] {
		OP_WR_TRANS = 2'd0,
		OP_WR_STAT  = 2'd1,
		OP_TEXT     = 2'd2,
		OP_EMPTY    = 2'd3
	} op_t;

	// One classified item on its way from the front to the back.
	typedef struct packed {
		logic       empty_item;
		logic       first;
		logic       last;
		logic       mode;
		logic [1:0] st0;
		logic [1:0] stnew;
	} q_entry_t;

	typedef struct packed {
		logic              head_valid;
		logic [QCNT_W-1:0] count;
	} q_status_t;

endpackage
`default_nettype wire

@@ src/dml_front.sv @@
`default_nettype none
module dml_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [dml_pkg::S_DATA_W-1:0]   s_tdata,
	input  wire logic [1:0]                     s_tuser,
	input  wire logic                           s_tlast,
	input  wire logic                           mode,
	input  wire logic [dml_pkg::QCNT_W-1:0]     q_count,
	output logic                                push,
	output dml_pkg::q_entry_t                   push_entry
);
	import dml_pkg::*;

	localparam int TR_DEPTH = 2 ** (ST_W + SYM_W);

	logic [ST_W-1:0]  trans_mem [TR_DEPTH];
	logic [1:0]       stat_mem [2 ** ST_W];

	logic             accept;
	op_t              op;
	logic [ST_W-1:0]  sidx;
	logic [SYM_W-1:0] sym;
	logic [ST_W-1:0]  nxt;
	logic [1:0]       sbits;
	logic             first;
	logic [ST_W-1:0]  rd_state;
	logic             sidx_ok;
	logic             nxt_ok;
	logic [QCNT_W:0]  inflight;

	logic [ST_W-1:0]  state_q;
	logic [1:0]       status0_q;
	logic             fresh_q;
	logic             v_s1;
	logic             v_s2;
	q_entry_t         ent_s1;
	q_entry_t         ent_s2;
	logic [1:0]       stnew_s2;

	assign op     = op_t'(s_tuser);
	assign sidx   = s_tdata[7:0];
	assign sym    = s_tdata[15:8];
	assign nxt    = s_tdata[23:16];
	assign sbits  = s_tdata[25:24];
	assign first  = s_tdata[26];

	assign sidx_ok = 32'(sidx) < NUM_STATES;
	assign nxt_ok  = 32'(nxt) < NUM_STATES;

	// reserve a queue slot for every item still inside the two read stages
	assign inflight = (QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(v_s1) + (QCNT_W + 1)'(v_s2);
	assign s_tready = inflight < (QCNT_W + 1)'(QDEPTH);
	assign accept   = s_tvalid & s_tready;

	// a new string walks from state 0; the table read output is the state itself
	assign rd_state = (first || fresh_q) ? '0 : state_q;

	always_ff @(posedge clk) begin
		if (accept && op == OP_WR_TRANS && sidx_ok && nxt_ok)
			trans_mem[{sidx, sym}] <= nxt;
		if (accept && op == OP_TEXT)
			state_q <= trans_mem[{rd_state, sym}];
	end

	always_ff @(posedge clk) begin
		if (accept && op == OP_WR_STAT && sidx_ok)
			stat_mem[sidx] <= sbits;
		stnew_s2 <= stat_mem[state_q];
	end

	// hold a copy of the start state's status for the start check
	always_ff @(posedge clk) begin
		if (accept && op == OP_WR_STAT && sidx == '0)
			status0_q <= sbits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= 1'b1;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			if (accept && op == OP_EMPTY)
				fresh_q <= 1'b1;
			else if (accept && op == OP_TEXT)
				fresh_q <= s_tlast;
			v_s1 <= accept && (op == OP_TEXT || op == OP_EMPTY);
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		ent_s1.empty_item <= (op == OP_EMPTY);
		ent_s1.first      <= first;
		ent_s1.last       <= s_tlast;
		ent_s1.mode       <= mode;
		ent_s1.st0        <= status0_q;
		ent_s1.stnew      <= '0;
		ent_s2            <= ent_s1;
	end

	always_comb begin
		push_entry       = ent_s2;
		push_entry.stnew = stnew_s2;
	end
	assign push = v_s2;

endmodule
`default_nettype wire

@@ src/dml_queue.sv @@
`default_nettype none
`include "dfa_match_length_defines.svh"
module dml_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire dml_pkg::q_entry_t   push_entry,
	input  wire logic                pop,
	output dml_pkg::q_entry_t        head,
	output dml_pkg::q_status_t       status
);
	import dml_pkg::*;

	q_entry_t          slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	assign head              = slot_q[rd_q];
	assign status.head_valid = cnt_q != '0;
	assign status.count      = cnt_q;

	`DML_ASSERT(a_q_no_overflow, push |-> (cnt_q < QCNT_W'(QDEPTH) || pop))
	`DML_ASSERT(a_q_no_underflow, pop |-> cnt_q != '0)
	`DML_ASSERT(a_q_ptr_gap, (cnt_q == '0 || cnt_q == QCNT_W'(QDEPTH)) |-> wr_q == rd_q)

endmodule
`default_nettype wire

@@ src/dml_back.sv @@
`default_nettype none
`include "dfa_match_length_defines.svh"
module dml_back (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire dml_pkg::q_entry_t                head,
	input  wire dml_pkg::q_status_t               q_status,
	output logic                                  pop,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [dml_pkg::M_DATA_W-1:0]          m_tdata
);
	import dml_pkg::*;

	logic                 best_valid_q;
	logic [LEN_W-1:0]     best_len_q;
	logic [LEN_W-1:0]     pos_q;
	logic                 stop_q;
	logic                 out_valid_q;
	logic                 out_found_q;
	logic [OUT_LEN_W-1:0] out_len_q;
	logic                 out_whole_q;

	logic                 nv;
	logic [LEN_W-1:0]     nl;
	logic [LEN_W-1:0]     np;
	logic                 ns;
	logic                 emit;
	logic                 found;
	logic [OUT_LEN_W-1:0] len_out;
	logic                 whole;

	assign pop = q_status.head_valid && (!out_valid_q || m_tready);

	always_comb begin
		nv      = best_valid_q;
		nl      = best_len_q;
		np      = pos_q;
		ns      = stop_q;
		emit    = 1'b0;
		found   = 1'b0;
		len_out = '0;
		whole   = 1'b0;
		if (head.empty_item) begin
			emit  = 1'b1;
			found = head.st0[0];
			whole = head.st0[0];
			nv = 1'b0;
			nl = '0;
			np = '0;
			ns = 1'b0;
		end else begin
			if (head.first) begin
				nv = 1'b0;
				nl = '0;
				np = '0;
				ns = 1'b0;
			end
			// start state check before the first step
			if (np == '0 && !ns) begin
				if ((head.st0 & STAT_ACCEPT) != '0) begin
					nv = 1'b1;
					nl = '0;
					if (head.mode)
						ns = 1'b1;
				end
				if ((head.st0 & STAT_REJECT) != '0)
					ns = 1'b1;
			end
			if (32'(np) < MAX_LENGTH)
				np = np + 1'b1;
			if (!ns) begin
				if ((head.stnew & STAT_ACCEPT) != '0) begin
					nv = 1'b1;
					nl = np;
					if (head.mode)
						ns = 1'b1;
				end
				if ((head.stnew & STAT_REJECT) != '0)
					ns = 1'b1;
			end
			if (head.last) begin
				emit  = 1'b1;
				found = nv;
				whole = nv && (nl == np);
				if (nv)
					len_out = (32'(nl) > OUT_LEN_MAX) ? OUT_LEN_W'(OUT_LEN_MAX)
						: OUT_LEN_W'(nl);
				nv = 1'b0;
				nl = '0;
				np = '0;
				ns = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_valid_q <= 1'b0;
			best_len_q   <= '0;
			pos_q        <= '0;
			stop_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				best_valid_q <= nv;
				best_len_q   <= nl;
				pos_q        <= np;
				stop_q       <= ns;
			end
			if (pop && emit)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			out_found_q <= found;
			out_len_q   <= len_out;
			out_whole_q <= whole;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_whole_q, out_len_q, out_found_q};

	`DML_ASSERT(a_back_clear_after_result, (pop && emit) |=> (pos_q == '0 && !best_valid_q))
	`DML_ASSERT(a_back_pop_needs_room, pop |-> (!out_valid_q || m_tready))
	`DML_ASSERT(a_back_whole_implies_found,
		(m_tvalid && out_whole_q) |-> out_found_q)

endmodule
`default_nettype wire

@@ src/dfa_match_length.sv @@
`default_nettype none
// A result beat reaches m_tdata after its last text byte or empty-string beat
// is accepted and passes the table read, status read, queue and output registers.
// Throughput: one input beat per cycle while the queue has room (s_tready high); the
// transition memory read feeds its own address through the state register, one read per text byte.
// Reset: arst_n clears the scan, queue and output valid at once; both DFA tables
// hold no reset value and must be loaded before use. No clearing pass is run.
module dfa_match_length (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,   // first_match_mode
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// state_index[7:0], symbol[15:8], next_state[23:16], status_bits[25:24],
	// first_of_string[26], zero pad[31:27]
	input  wire logic [31:0] s_tdata,
	input  wire logic [1:0]  s_tuser,     // operation[1:0]
	input  wire logic        s_tlast,     // last_of_string
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// match_found[0], match_length[16:1], whole_match[17], zero pad[23:18]
	output logic [23:0]      m_tdata
);
	import dml_pkg::*;

	logic      mode_q;
	logic      push;
	q_entry_t  push_entry;
	q_entry_t  head;
	q_status_t q_status;
	logic      pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= 1'b0;
		else if (cfg_we)
			mode_q <= cfg_wdata;
	end

	dml_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.mode       (mode_q),
		.q_count    (q_status.count),
		.push       (push),
		.push_entry (push_entry)
	);

	dml_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	dml_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
`default_nettype wire
